@@ rtl/kcc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the keyword class counter.
// Holds the dictionary, the verdict codes and the front-to-back event type.
// No dependencies.
package kcc_pkg;

   localparam int MAX_WORD_DEFAULT   = 127;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int OUT_BITS           = 16;

   localparam int DICT_SIZE     = 10;
   localparam int DICT_POSITIVE = 5;
   localparam int ENTRY_SLOTS   = 16;
   localparam int SLOT_BITS     = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [1:0] VERDICT_NEUTRAL  = 2'd0;
   localparam logic [1:0] VERDICT_POSITIVE = 2'd1;
   localparam logic [1:0] VERDICT_NEGATIVE = 2'd2;

   localparam logic [7:0] DICT_TEXT [DICT_SIZE][ENTRY_SLOTS] = '{
      '{0: "b", 1: "u", 2: "e", 3: "n", 4: "o", default: 8'h00},
      '{0: "e", 1: "x", 2: "c", 3: "e", 4: "l", 5: "e", 6: "n", 7: "t", 8: "e",
        default: 8'h00},
      '{0: "f", 1: "e", 2: "l", 3: "i", 4: "z", default: 8'h00},
      '{0: "h", 1: "o", 2: "l", 3: "a", default: 8'h00},
      '{0: "a", 1: "m", 2: "o", 3: "r", default: 8'h00},
      '{0: "m", 1: "a", 2: "l", 3: "o", default: 8'h00},
      '{0: "t", 1: "r", 2: "i", 3: "s", 4: "t", 5: "e", default: 8'h00},
      '{0: "o", 1: "d", 2: "i", 3: "o", default: 8'h00},
      '{0: "h", 1: "o", 2: "r", 3: "r", 4: "i", 5: "b", 6: "l", 7: "e",
        default: 8'h00},
      '{0: "f", 1: "e", 2: "o", default: 8'h00}
   };

   localparam logic [SLOT_BITS-1:0] DICT_LEN [DICT_SIZE] = '{
      4'd5, 4'd9, 4'd5, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd8, 4'd3
   };

   typedef struct packed {
      logic pos_hit;
      logic neg_hit;
      logic last;
   } kcc_event_type;

endpackage

@@ rtl/kcc_front.sv @@
`timescale 1ns / 1ps
// Front part of the keyword class counter: folds case, tracks the word prefix
// against the dictionary and emits one event per matching word or text end.
// Depends on kcc_pkg.
module kcc_front #(
   parameter int MAX_WORD = kcc_pkg::MAX_WORD_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  ev_ready,
   output logic                  ev_valid,
   output kcc_pkg::kcc_event_type ev_data
);
   import kcc_pkg::*;

   localparam int LW = $clog2(MAX_WORD + 1);

   logic [LW-1:0]        len_ff, len_in, len_t;
   logic [DICT_SIZE-1:0] alive_ff, alive_in, alive_t, keep, full_match;
   logic [7:0]           ch;
   logic                 is_letter, take, finish, accept;

   assign req_tready = ev_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ch = req_tdata;
      if (req_tdata >= "A" && req_tdata <= "Z") begin
         ch = req_tdata + 8'd32;
      end
      is_letter = (ch >= "a") && (ch <= "z");
      take      = is_letter && (len_ff < LW'(MAX_WORD));
      finish    = !is_letter || req_tlast;
      for (int i = 0; i < DICT_SIZE; i++) begin
         keep[i] = (len_ff < {{(LW-SLOT_BITS){1'b0}}, DICT_LEN[i]}) &&
                   (DICT_TEXT[i][len_ff[SLOT_BITS-1:0]] == ch);
      end
      len_t   = take ? len_ff + LW'(1) : len_ff;
      alive_t = take ? (alive_ff & keep) : alive_ff;
      for (int i = 0; i < DICT_SIZE; i++) begin
         full_match[i] = alive_t[i] && (len_t != '0) &&
                         (len_t == {{(LW-SLOT_BITS){1'b0}}, DICT_LEN[i]});
      end
      ev_data.pos_hit = finish && (|full_match[DICT_POSITIVE-1:0]);
      ev_data.neg_hit = finish && (|full_match[DICT_SIZE-1:DICT_POSITIVE]);
      ev_data.last    = req_tlast;
      ev_valid = accept && (ev_data.pos_hit || ev_data.neg_hit || req_tlast);
      if (finish) begin
         len_in   = '0;
         alive_in = '1;
      end else begin
         len_in   = len_t;
         alive_in = alive_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         alive_ff <= '1;
      end else if (accept) begin
         len_ff   <= len_in;
         alive_ff <= alive_in;
      end
   end

endmodule

@@ rtl/kcc_queue.sv @@
`timescale 1ns / 1ps
// Short event queue between the front and back parts of the keyword class
// counter. Depends on kcc_pkg.
module kcc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  kcc_pkg::kcc_event_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output kcc_pkg::kcc_event_type out_data
);
   import kcc_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   kcc_event_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != CW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = push ? wr_ff + QUEUE_AW'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QUEUE_AW'(1) : rd_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/kcc_back.sv @@
`timescale 1ns / 1ps
// Back part of the keyword class counter: keeps the saturating tallies and
// holds the result of each text in an output register. Depends on kcc_pkg.
module kcc_back #(
   parameter int COUNT_BITS = kcc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ev_valid,
   output logic                   ev_ready,
   input  kcc_pkg::kcc_event_type ev_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata
);
   import kcc_pkg::*;

   logic [COUNT_BITS-1:0]          pos_ff, pos_in, pos_next;
   logic [COUNT_BITS-1:0]          neg_ff, neg_in, neg_next;
   logic [COUNT_BITS+OUT_BITS-1:0] pos_ext, neg_ext;
   logic                           valid_ff, valid_in, pop, load;
   logic [OUT_BITS-1:0]            pos_out_ff, pos_out_in, neg_out_ff, neg_out_in;
   logic [1:0]                     verdict_ff, verdict_in;

   assign ev_ready   = !(ev_data.last && valid_ff && !rsp_tready);
   assign pop        = ev_valid && ev_ready;
   assign load       = pop && ev_data.last;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, verdict_ff, neg_out_ff, pos_out_ff};

   always_comb begin
      pos_next = pos_ff;
      neg_next = neg_ff;
      if (ev_data.pos_hit && (pos_ff != '1)) begin
         pos_next = pos_ff + COUNT_BITS'(1);
      end
      if (ev_data.neg_hit && (neg_ff != '1)) begin
         neg_next = neg_ff + COUNT_BITS'(1);
      end
      pos_ext    = {{OUT_BITS{1'b0}}, pos_next};
      neg_ext    = {{OUT_BITS{1'b0}}, neg_next};
      pos_out_in = pos_ext[OUT_BITS-1:0];
      neg_out_in = neg_ext[OUT_BITS-1:0];
      if (pos_next > neg_next) begin
         verdict_in = VERDICT_POSITIVE;
      end else if (neg_next > pos_next) begin
         verdict_in = VERDICT_NEGATIVE;
      end else begin
         verdict_in = VERDICT_NEUTRAL;
      end
      pos_in = pos_ff;
      neg_in = neg_ff;
      if (pop) begin
         pos_in = ev_data.last ? '0 : pos_next;
         neg_in = ev_data.last ? '0 : neg_next;
      end
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         neg_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_out_ff <= pos_out_in;
         neg_out_ff <= neg_out_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

@@ rtl/keyword_class_counter.sv @@
`timescale 1ns / 1ps
// Keyword class counter, top level: front part, event queue and back part.
// Depends on kcc_pkg, kcc_front, kcc_queue and kcc_back.
//
// The req channel takes one text byte per item, tlast marking the final byte
// of a text. Letters are folded to lower case and form words; every other
// byte ends a word. Each finished word that matches one of five positive or
// five negative dictionary words adds to a saturating tally.
// On the final byte the rsp channel gives one item: both counts and a
// verdict (0 neutral, 1 positive, 2 negative). The tallies then clear.
// Throughput is one byte per cycle while req_tready is high. The front part
// updates the per-word match bits for every byte and pushes an event into a
// four-entry queue only for a matching word or the end of a text.
// With no earlier event waiting, the end-of-text event for the final byte is
// registered in the queue and then loads the output register of the back
// part, which raises rsp_tvalid.
// While rsp is stalled the back part still drains word events; only a
// second end-of-text event waits, and bytes keep flowing until the queue
// fills, after which req_tready drops.
// Reset clears the word state, the tallies, the queue and rsp_tvalid.
module keyword_class_counter #(
   parameter int MAX_WORD   = kcc_pkg::MAX_WORD_DEFAULT,
   parameter int COUNT_BITS = kcc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // positive_count, negative_count, verdict, zeros
);
   import kcc_pkg::*;

   kcc_event_type front_ev, back_ev;
   logic          front_valid, front_ready, back_valid, back_ready;

   kcc_front #(
      .MAX_WORD(MAX_WORD)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .ev_ready(front_ready),
      .ev_valid(front_valid),
      .ev_data(front_ev)
   );

   kcc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .in_valid(front_valid),
      .in_ready(front_ready),
      .in_data(front_ev),
      .out_valid(back_valid),
      .out_ready(back_ready),
      .out_data(back_ev)
   );

   kcc_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .ev_valid(back_valid),
      .ev_ready(back_ready),
      .ev_data(back_ev),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule
